// ----- rtl/fpr_pkg.sv -----
// shared widths, constants and register codes of the fisheye pixel remap
package fpr_pkg;

  // field widths
  localparam int CRD_W   = 12;   // source coordinate
  localparam int DIM_W   = 13;   // frame dimension, mapped coordinate
  localparam int OFF_W   = 14;   // offset from centre in half pixels, signed
  localparam int Q_W     = 28;   // squared radius in quarter pixels
  localparam int DIV_W   = 80;   // quotient of the ratio numerator by the squared radius
  localparam int SQ1_W   = DIV_W / 2;
  localparam int RATIO_W = SQ1_W / 2;  // q4.16 ratio
  localparam int SIDE_W  = 2 * OFF_W + 1;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = OFF_W + RATIO_W + 1;
  localparam int NUM_W   = PROD_W + 1;
  localparam int DST_W   = NUM_W - FRAC_W - 1;

  // 4 * 655360^4 = 10000 * 2^66
  localparam logic [DIV_W-1:0] RATIO_NUM = 80'd10000 << 66;

  localparam logic [DIM_W-1:0] DIM_RESET = 13'd512;

  // configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // sideband carried along the ratio pipeline
  typedef struct packed {
    logic                    zero;
    logic signed [OFF_W-1:0] ox;
    logic signed [OFF_W-1:0] oy;
  } side_t;

endpackage

// ----- rtl/fpr_div.sv -----
// pipelined restoring divider of the ratio numerator by the squared radius, one bit a stage
module fpr_div import fpr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [Q_W-1:0]    in_den,
  input  side_t             in_side,
  output logic              out_vld,
  output logic [DIV_W-1:0]  out_quo,
  output side_t             out_side
);

  logic [Q_W-1:0]   rem_r  [DIV_W];
  logic [DIV_W-1:0] quo_r  [DIV_W];
  logic [Q_W-1:0]   den_r  [DIV_W];
  side_t            side_r [DIV_W];
  logic [DIV_W-1:0] vld_r;

  genvar k;
  generate
    for (k = 0; k < DIV_W; k++) begin : g_stage
      logic [Q_W-1:0]   s_rem;
      logic [DIV_W-1:0] s_quo;
      logic [Q_W-1:0]   s_den;
      side_t            s_side;
      logic             s_vld;
      logic [Q_W:0]     trial;
      logic [Q_W:0]     diff;
      logic             ge;

      if (k == 0) begin : g_first
        assign s_rem  = '0;
        assign s_quo  = '0;
        assign s_den  = in_den;
        assign s_side = in_side;
        assign s_vld  = in_vld;
      end else begin : g_next
        assign s_rem  = rem_r[k-1];
        assign s_quo  = quo_r[k-1];
        assign s_den  = den_r[k-1];
        assign s_side = side_r[k-1];
        assign s_vld  = vld_r[k-1];
      end

      // bring down next numerator bit, subtract when it fits
      assign trial = {s_rem, RATIO_NUM[DIV_W-1-k]};
      assign diff  = trial - {1'b0, s_den};
      assign ge    = (trial >= {1'b0, s_den});

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (en) begin
          vld_r[k] <= s_vld;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k]  <= ge ? diff[Q_W-1:0] : trial[Q_W-1:0];
          quo_r[k]  <= {s_quo[DIV_W-2:0], ge};
          den_r[k]  <= s_den;
          side_r[k] <= s_side;
        end
      end
    end
  endgenerate

  assign out_vld  = vld_r[DIV_W-1];
  assign out_quo  = quo_r[DIV_W-1];
  assign out_side = side_r[DIV_W-1];

endmodule

// ----- rtl/fpr_isqrt.sv -----
// pipelined integer square root, one result bit a stage
module fpr_isqrt import fpr_pkg::*; #(
  parameter int W = SQ1_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [W-1:0]     in_rad,
  input  side_t            in_side,
  output logic             out_vld,
  output logic [W/2-1:0]   out_root,
  output side_t            out_side
);

  localparam int R = W / 2;

  logic [W-1:0]   rad_r  [R];
  logic [R+1:0]   rem_r  [R];
  logic [R-1:0]   root_r [R];
  side_t          side_r [R];
  logic [R-1:0]   vld_r;

  genvar k;
  generate
    for (k = 0; k < R; k++) begin : g_stage
      logic [W-1:0] s_rad;
      logic [R+1:0] s_rem;
      logic [R-1:0] s_root;
      side_t        s_side;
      logic         s_vld;
      logic [R+3:0] cur;
      logic [R+3:0] trial;
      logic [R+3:0] diff;
      logic         ge;

      if (k == 0) begin : g_first
        assign s_rad  = in_rad;
        assign s_rem  = '0;
        assign s_root = '0;
        assign s_side = in_side;
        assign s_vld  = in_vld;
      end else begin : g_next
        assign s_rad  = rad_r[k-1];
        assign s_rem  = rem_r[k-1];
        assign s_root = root_r[k-1];
        assign s_side = side_r[k-1];
        assign s_vld  = vld_r[k-1];
      end

      // shift in next two radicand bits, try root*4+1
      assign cur   = {s_rem, s_rad[W-1 -: 2]};
      assign trial = {s_root, 2'b01};
      assign diff  = cur - trial;
      assign ge    = (cur >= trial);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (en) begin
          vld_r[k] <= s_vld;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[k]  <= {s_rad[W-3:0], 2'b00};
          rem_r[k]  <= ge ? diff[R+1:0] : cur[R+1:0];
          root_r[k] <= {s_root[R-2:0], ge};
          side_r[k] <= s_side;
        end
      end
    end
  endgenerate

  assign out_vld  = vld_r[R-1];
  assign out_root = root_r[R-1];
  assign out_side = side_r[R-1];

endmodule

// ----- rtl/fisheye_pixel_remap_top.sv -----
// Fisheye pixel remap: maps a source pixel radially about the frame centre. The pipeline
// has a 3-stage front end forming the offsets and squared radius, an 80-stage divider,
// square roots of 40 and 20 stages, and 3 stages of scaling, centre addition and truncated
// output; one coordinate is taken every cycle. The Q4.16 ratio is exact: the floored fourth root
// of 10000*2^66 over the squared radius, taken as two nested integer square roots.
// All stages stall together while the output holds an item that is not taken.
module fisheye_pixel_remap_top import fpr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_addr,
  input  logic [DIM_W-1:0]        cfg_wdata,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [2*CRD_W-1:0]      in_tdata,   // src_x, src_y
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [31:0]             out_tdata,  // dest_x, dest_y, zero fill
  output logic                    out_tuser   // in_frame
);

  logic [DIM_W-1:0] width_r, height_r;
  logic             en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_WIDTH:  width_r  <= cfg_wdata;
        CFG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the output item waits
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 0: offsets in half pixels
  logic                    v0_r;
  logic signed [OFF_W-1:0] ox0_r, oy0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ox0_r <= $signed({1'b0, in_tdata[CRD_W-1:0], 1'b0}) - $signed({1'b0, width_r});
      oy0_r <= $signed({1'b0, in_tdata[2*CRD_W-1:CRD_W], 1'b0}) - $signed({1'b0, height_r});
    end
  end

  // stage 1: squares
  logic                    v1_r;
  logic signed [OFF_W-1:0] ox1_r, oy1_r;
  logic [Q_W-2:0]          sqx1_r, sqy1_r;
  logic signed [2*OFF_W-1:0] sqx, sqy;
  assign sqx = ox0_r * ox0_r;
  assign sqy = oy0_r * oy0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= v0_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ox1_r  <= ox0_r;
      oy1_r  <= oy0_r;
      sqx1_r <= sqx[Q_W-2:0];
      sqy1_r <= sqy[Q_W-2:0];
    end
  end

  // stage 2: squared radius and centre flag
  logic           v2_r;
  logic [Q_W-1:0] q2_r;
  side_t          side2_r;
  logic [Q_W-1:0] q_nxt;
  assign q_nxt = {1'b0, sqx1_r} + {1'b0, sqy1_r};
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      q2_r         <= q_nxt;
      side2_r.zero <= (q_nxt == '0);
      side2_r.ox   <= ox1_r;
      side2_r.oy   <= oy1_r;
    end
  end

  // ratio: floor(sqrt(sqrt(floor(num / q))))
  logic               vd, vs1, vs2;
  logic [DIV_W-1:0]   quo;
  logic [SQ1_W-1:0]   root1;
  logic [RATIO_W-1:0] ratio;
  side_t              sided, sides1, sides2;

  fpr_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(v2_r), .in_den(q2_r), .in_side(side2_r),
    .out_vld(vd), .out_quo(quo), .out_side(sided)
  );

  fpr_isqrt #(.W(DIV_W)) u_sqrt_a (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(vd), .in_rad(quo), .in_side(sided),
    .out_vld(vs1), .out_root(root1), .out_side(sides1)
  );

  fpr_isqrt #(.W(SQ1_W)) u_sqrt_b (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(vs1), .in_rad(root1), .in_side(sides1),
    .out_vld(vs2), .out_root(ratio), .out_side(sides2)
  );

  // stage m: offset times ratio
  logic                     vm_r, zm_r;
  logic signed [PROD_W-1:0] px_r, py_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vm_r <= 1'b0;
    else if (en) vm_r <= vs2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      zm_r <= sides2.zero;
      px_r <= sides2.ox * $signed({1'b0, ratio});
      py_r <= sides2.oy * $signed({1'b0, ratio});
    end
  end

  // stage a: add centre term
  logic                    va_r, za_r;
  logic signed [NUM_W-1:0] nx_r, ny_r;
  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else if (en) va_r <= vm_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      za_r <= zm_r;
      nx_r <= $signed({{(NUM_W-DIM_W-FRAC_W){1'b0}}, width_r, {FRAC_W{1'b0}}})
              + {px_r[PROD_W-1], px_r};
      ny_r <= $signed({{(NUM_W-DIM_W-FRAC_W){1'b0}}, height_r, {FRAC_W{1'b0}}})
              + {py_r[PROD_W-1], py_r};
    end
  end

  // truncate toward zero, centre case, frame check and saturation
  localparam logic signed [NUM_W-1:0] RND = (NUM_W'(1) <<< (FRAC_W + 1)) - NUM_W'(1);
  logic signed [NUM_W-1:0] adjx, adjy;
  logic signed [DST_W-1:0] dx, dy;
  logic signed [DST_W-1:0] wext, hext;
  logic                    frame_nxt;
  logic [DIM_W-1:0]        satx, saty;

  assign adjx = nx_r[NUM_W-1] ? nx_r + RND : nx_r;
  assign adjy = ny_r[NUM_W-1] ? ny_r + RND : ny_r;
  assign wext = $signed({{(DST_W-DIM_W){1'b0}}, width_r});
  assign hext = $signed({{(DST_W-DIM_W){1'b0}}, height_r});
  assign dx   = za_r ? (wext >>> 1) : adjx[NUM_W-1:FRAC_W+1];
  assign dy   = za_r ? (hext >>> 1) : adjy[NUM_W-1:FRAC_W+1];
  assign frame_nxt = !dx[DST_W-1] && (dx < wext) && !dy[DST_W-1] && (dy < hext);

  always_comb begin
    if (dx < -$signed(DST_W'(4096)))      satx = 13'h1000;
    else if (dx > $signed(DST_W'(4095)))  satx = 13'h0FFF;
    else                                   satx = dx[DIM_W-1:0];
    if (dy < -$signed(DST_W'(4096)))      saty = 13'h1000;
    else if (dy > $signed(DST_W'(4095)))  saty = 13'h0FFF;
    else                                   saty = dy[DIM_W-1:0];
  end

  // output register
  logic             ov_r, of_r;
  logic [DIM_W-1:0] odx_r, ody_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (en) ov_r <= va_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      odx_r <= satx;
      ody_r <= saty;
      of_r  <= frame_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {{(32-2*DIM_W){1'b0}}, ody_r, odx_r};
  assign out_tuser  = of_r;

endmodule

// ----- tb/fisheye_pixel_remap_top_test.sv -----
// testbench for the fisheye pixel remap: directed and random pixels checked against a predictor
`timescale 1ns / 1ps

module fisheye_pixel_remap_top_test import fpr_pkg::*; ();

  typedef struct {
    logic signed [DIM_W-1:0] dest_x;
    logic signed [DIM_W-1:0] dest_y;
    logic                    in_frame;
  } remap_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_addr;
  logic [DIM_W-1:0]   cfg_wdata;
  logic               in_tvalid;
  logic               in_tready;
  logic [2*CRD_W-1:0] in_tdata;    // src_x, src_y
  logic               out_tvalid;
  logic               out_tready;
  logic [31:0]        out_tdata;   // dest_x, dest_y, zero fill
  logic               out_tuser;   // in_frame

  // predictor copy of the frame size
  int unsigned frame_w;
  int unsigned frame_h;
  remap_t      pending_pixels[$];
  int          fail_count;
  int          send_idle_pct;
  int          recv_idle_pct;

  fisheye_pixel_remap_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // largest q4.16 ratio r with r^4 * q <= 10000 * 2^66
  function automatic longint fisheye_ratio(longint q);
    logic [127:0] bound;
    logic [127:0] prod;
    longint       lo;
    longint       hi;
    longint       mid;
    bound = 128'd10000 << 66;
    lo = 0;
    hi = (1 << 20) - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      prod = 128'(mid) * 128'(mid) * 128'(mid) * 128'(mid) * 128'(q);
      if (prod <= bound) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic logic signed [DIM_W-1:0] clamp13(longint v);
    if (v < -4096) v = -4096;
    if (v > 4095) v = 4095;
    return v[DIM_W-1:0];
  endfunction

  function automatic remap_t predict_remap(int unsigned sx, int unsigned sy);
    remap_t res;
    longint w;
    longint h;
    longint ox;
    longint oy;
    longint q;
    longint r;
    longint nx;
    longint ny;
    w = frame_w;
    h = frame_h;
    ox = 2 * longint'(sx) - w;
    oy = 2 * longint'(sy) - h;
    q = ox * ox + oy * oy;
    // centre pixel: truncated centre, no scaling
    if (q == 0) begin
      nx = w / 2;
      ny = h / 2;
    end else begin
      r = fisheye_ratio(q);
      nx = (w * 65536 + ox * r) / 131072;
      ny = (h * 65536 + oy * r) / 131072;
    end
    res.dest_x = clamp13(nx);
    res.dest_y = clamp13(ny);
    res.in_frame = (nx >= 0 && nx < w && ny >= 0 && ny < h);
    return res;
  endfunction

  // send one pixel; valid stays high into the next call unless a gap is taken
  task automatic send_pixel(int unsigned sx, int unsigned sy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {sy[CRD_W-1:0], sx[CRD_W-1:0]};
    do @(posedge clk); while (!in_tready);
    pending_pixels.insert(pending_pixels.size(), predict_remap(sx, sy));
    @(negedge clk);
  endtask

  // drain, let the pipeline settle, then write a register
  task automatic write_frame_reg(logic idx, int unsigned value);
    in_tvalid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (160) @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = value[DIM_W-1:0];
    if (idx == CFG_WIDTH) frame_w = value & 32'h1FFF;
    else frame_h = value & 32'h1FFF;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_frame(int unsigned w, int unsigned h);
    write_frame_reg(CFG_WIDTH, w);
    write_frame_reg(CFG_HEIGHT, h);
  endtask

  // corners, centre and axis extremes at the reset frame size
  task automatic test_directed_extremes();
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(0, 4095);
    send_pixel(4095, 0);
    send_pixel(256, 256);
    send_pixel(257, 256);
    send_pixel(256, 255);
    send_pixel(511, 511);
    send_pixel(512, 512);
    send_pixel(2730, 1365);
    send_pixel(256, 0);
    send_pixel(0, 256);
  endtask

  // odd and unit frame sizes: centre on a half pixel and the smallest frame
  task automatic test_directed_odd_frames();
    set_frame(1, 1);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(1, 0);
    set_frame(4095, 3);
    send_pixel(2047, 1);
    send_pixel(2048, 1);
    send_pixel(0, 0);
  endtask

  // out-of-range sizes: zero frame and widest register value, outputs saturate
  task automatic test_directed_out_of_range();
    set_frame(0, 8191);
    send_pixel(0, 0);
    send_pixel(0, 4095);
    send_pixel(4095, 4095);
    send_pixel(0, 4095);
    set_frame(8191, 0);
    send_pixel(0, 0);
    send_pixel(4095, 0);
  endtask

  // about half the pixels inside the frame, some anywhere, some at or next to the centre
  task automatic test_random_pixels(int count);
    int unsigned sx;
    int unsigned sy;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(9);
      if (pick < 5 && frame_w > 0 && frame_h > 0) begin
        sx = $urandom_range((frame_w > 4096 ? 4096 : frame_w) - 1);
        sy = $urandom_range((frame_h > 4096 ? 4096 : frame_h) - 1);
      end else if (pick == 5) begin
        sx = (frame_w / 2 + $urandom_range(2)) & 12'hFFF;
        sy = (frame_h / 2 + $urandom_range(2)) & 12'hFFF;
      end else begin
        sx = $urandom_range(4095);
        sy = $urandom_range(4095);
      end
      send_pixel(sx, sy);
    end
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    remap_t exp_px;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result dest_x=%0d dest_y=%0d",
               $signed(out_tdata[12:0]), $signed(out_tdata[25:13]));
        fail_count++;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (out_tdata[12:0] !== exp_px.dest_x) begin
          $error("dest_x expected %0d actual %0d", exp_px.dest_x, $signed(out_tdata[12:0]));
          fail_count++;
        end
        if (out_tdata[25:13] !== exp_px.dest_y) begin
          $error("dest_y expected %0d actual %0d", exp_px.dest_y, $signed(out_tdata[25:13]));
          fail_count++;
        end
        if (out_tuser !== exp_px.in_frame) begin
          $error("in_frame expected %0d actual %0d", exp_px.in_frame, out_tuser);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int settle;
    fail_count = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_WIDTH;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    frame_w = 512;
    frame_h = 512;
    send_idle_pct = 13;
    recv_idle_pct = 68;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_directed_extremes();
    set_frame(4096, 4096);
    test_random_pixels(250);
    set_frame(640, 480);
    test_random_pixels(200);

    send_idle_pct = 68;
    recv_idle_pct = 13;
    test_directed_odd_frames();
    set_frame(1, 4096);
    test_random_pixels(120);
    set_frame(1023, 77);
    test_random_pixels(250);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_directed_out_of_range();
    set_frame(333, 2049);
    test_random_pixels(350);

    // drain and let any straggler show up
    in_tvalid = 1'b0;
    settle = 0;
    while (pending_pixels.size() != 0 && settle < 100000) begin
      @(negedge clk);
      settle++;
    end
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
